// ===== rtl/srld_pkg.sv =====
// Shared constants and types for the sprite RLE line decoder.
package srld_pkg;

    localparam int ADDR_BITS    = 18;
    localparam int HEADER_BYTES = 6;

    localparam int PTR_W      = ADDR_BITS + 1;
    localparam int PITCH_W    = 16;
    localparam int LCNT_W     = 8;
    localparam int OPB_W      = PITCH_W + LCNT_W - 1;
    localparam int SUM_W      = ((PTR_W > OPB_W) ? PTR_W : OPB_W) + 1;
    localparam int PIX_ADDR_W = 18;
    localparam int PIX_VAL_W  = 8;
    localparam int ADDR_X_W   = (PTR_W > PIX_ADDR_W) ? PTR_W : PIX_ADDR_W;
    localparam int TDATA_O_W  = 32;

    localparam logic [PTR_W-1:0] PTR_MAX = {PTR_W{1'b1}};

    localparam logic [1:0] OPC_COPY = 2'd0;
    localparam logic [1:0] OPC_FILL = 2'd1;
    localparam logic [1:0] OPC_SKIP = 2'd2;
    localparam logic [1:0] OPC_LINE = 2'd3;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [OPB_W-1:0] t_opb;

endpackage

// ===== rtl/sprite_rle_line_decoder.sv =====
// Top level: byte parser, pixel sequencer and output register.
// A result word is registered from its sequencer step and shown in the next cycle.
// Each byte takes an input step. A skip adds an add step; a literal byte, a pixel
// step; a fill, a pixel step per pixel; a line jump, 8 shift-add steps of the shared
// adder and a column step; the end word, an end step; stalls hold pixel/end steps.
// Reset (synchronous, active low) clears the parser and sets the pitch to 256.
module sprite_rle_line_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,     // line_pitch
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // comp_byte
    input  logic [0:0]  s_axis_tuser,   // sprite_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // pixel_addr[17:0], pixel_value[25:18], zeros
    output logic [1:0]  m_axis_tuser,   // is_end, overflow
    output logic        m_axis_tlast    // last
);

    localparam logic [2:0] PH_HEADER     = 3'd0;
    localparam logic [2:0] PH_CTRL       = 3'd1;
    localparam logic [2:0] PH_LITERAL    = 3'd2;
    localparam logic [2:0] PH_FILL_VAL   = 3'd3;
    localparam logic [2:0] PH_SKIP_BYTE  = 3'd4;
    localparam logic [2:0] PH_LINE_COUNT = 3'd5;
    localparam logic [2:0] PH_LINE_COL   = 3'd6;
    localparam logic [2:0] PH_DONE       = 3'd7;

    localparam logic [2:0] ST_IN  = 3'd0;
    localparam logic [2:0] ST_PIX = 3'd1;
    localparam logic [2:0] ST_ADD = 3'd2;
    localparam logic [2:0] ST_MUL = 3'd3;
    localparam logic [2:0] ST_COL = 3'd4;
    localparam logic [2:0] ST_END = 3'd5;

    localparam logic [2:0] PH_RESET = (srld_pkg::HEADER_BYTES != 0) ? PH_HEADER : PH_CTRL;
    localparam logic [2:0] HDR_RESET = 3'(srld_pkg::HEADER_BYTES);

    logic [2:0]                         r_st, n_st;
    logic [2:0]                         r_phase, n_phase;
    logic [2:0]                         r_hdr_left, n_hdr_left;
    logic [5:0]                         r_lit_left, n_lit_left;
    logic [7:0]                         r_pend, n_pend;
    logic                               r_ovf, n_ovf;
    srld_pkg::t_ptr                     r_base, n_base;
    srld_pkg::t_ptr                     r_wptr, n_wptr;
    logic [srld_pkg::PITCH_W-1:0]       r_pitch;
    logic [5:0]                         r_cnt, n_cnt;
    logic [7:0]                         r_val, n_val;
    srld_pkg::t_opb                     r_opb, n_opb;
    logic [2:0]                         r_k, n_k;
    logic                               r_ovld, n_ovld;
    logic [srld_pkg::PIX_ADDR_W-1:0]    r_oaddr, n_oaddr;
    logic [srld_pkg::PIX_VAL_W-1:0]     r_oval, n_oval;
    logic                               r_oend, n_oend;
    logic                               r_oovf, n_oovf;
    logic                               r_olast, n_olast;

    logic [2:0]                         e_phase;
    logic [2:0]                         e_hdr_left;
    logic [5:0]                         e_lit_left;
    logic [7:0]                         e_pend;
    logic                               e_ovf;
    srld_pkg::t_ptr                     e_base;
    srld_pkg::t_ptr                     e_wptr;

    srld_pkg::t_ptr                     w_alu_a;
    srld_pkg::t_opb                     w_alu_b;
    srld_pkg::t_ptr                     w_alu_sum;
    logic [srld_pkg::ADDR_X_W-1:0]      w_wptr_x;
    logic                               w_accept;
    logic                               w_can_emit;
    logic [1:0]                         w_opc;
    logic [5:0]                         w_cnt;
    logic [7:0]                         w_b;

    srld_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_sum (w_alu_sum)
    );

    assign s_axis_tready = (r_st == ST_IN);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_can_emit    = !r_ovld || m_axis_tready;
    assign w_b           = s_axis_tdata;
    assign w_opc         = w_b[7:6];
    assign w_cnt         = w_b[5:0];
    assign w_wptr_x      = srld_pkg::ADDR_X_W'(r_wptr);

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {{(srld_pkg::TDATA_O_W - srld_pkg::PIX_ADDR_W
                             - srld_pkg::PIX_VAL_W){1'b0}}, r_oval, r_oaddr};
    assign m_axis_tuser  = {r_oovf, r_oend};
    assign m_axis_tlast  = r_olast;

    // clear on sprite start
    always_comb begin
        if (s_axis_tuser[0]) begin
            e_phase    = PH_RESET;
            e_hdr_left = HDR_RESET;
            e_lit_left = '0;
            e_pend     = '0;
            e_ovf      = 1'b0;
            e_base     = '0;
            e_wptr     = '0;
        end else begin
            e_phase    = r_phase;
            e_hdr_left = r_hdr_left;
            e_lit_left = r_lit_left;
            e_pend     = r_pend;
            e_ovf      = r_ovf;
            e_base     = r_base;
            e_wptr     = r_wptr;
        end
    end

    always_comb begin
        w_alu_a = r_wptr;
        w_alu_b = srld_pkg::OPB_W'(1);
        unique case (r_st)
            ST_ADD: w_alu_b = r_opb;
            ST_MUL: begin
                w_alu_a = r_base;
                w_alu_b = r_pend[r_k] ? (srld_pkg::OPB_W'(r_pitch) << r_k) : '0;
            end
            ST_COL: begin
                w_alu_a = r_base;
                w_alu_b = srld_pkg::OPB_W'(r_val);
            end
            default: w_alu_b = srld_pkg::OPB_W'(1);
        endcase
    end

    always_comb begin
        n_st       = r_st;
        n_phase    = r_phase;
        n_hdr_left = r_hdr_left;
        n_lit_left = r_lit_left;
        n_pend     = r_pend;
        n_ovf      = r_ovf;
        n_base     = r_base;
        n_wptr     = r_wptr;
        n_cnt      = r_cnt;
        n_val      = r_val;
        n_opb      = r_opb;
        n_k        = r_k;
        n_ovld     = r_ovld && !m_axis_tready;
        n_oaddr    = r_oaddr;
        n_oval     = r_oval;
        n_oend     = r_oend;
        n_oovf     = r_oovf;
        n_olast    = r_olast;

        unique case (r_st)
            ST_IN: begin
                if (w_accept) begin
                    n_phase    = e_phase;
                    n_hdr_left = e_hdr_left;
                    n_lit_left = e_lit_left;
                    n_pend     = e_pend;
                    n_ovf      = e_ovf;
                    n_base     = e_base;
                    n_wptr     = e_wptr;
                    unique case (e_phase)
                        PH_HEADER: begin
                            n_hdr_left = (e_hdr_left != 3'd0) ? e_hdr_left - 3'd1 : 3'd0;
                            if (n_hdr_left == 3'd0) begin
                                n_phase = PH_CTRL;
                            end
                        end
                        PH_CTRL: begin
                            unique case (w_opc)
                                srld_pkg::OPC_COPY: begin
                                    n_lit_left = w_cnt;
                                    n_phase    = (w_cnt != 6'd0) ? PH_LITERAL : PH_CTRL;
                                end
                                srld_pkg::OPC_FILL: begin
                                    n_pend  = 8'(w_cnt);
                                    n_phase = PH_FILL_VAL;
                                end
                                srld_pkg::OPC_SKIP: begin
                                    if (w_cnt == 6'd0) begin
                                        n_phase = PH_SKIP_BYTE;
                                    end else begin
                                        n_opb = srld_pkg::OPB_W'(w_cnt);
                                        n_st  = ST_ADD;
                                    end
                                end
                                default: begin
                                    if (w_cnt == 6'd0) begin
                                        n_phase = PH_LINE_COUNT;
                                    end else begin
                                        n_pend  = 8'(w_cnt);
                                        n_phase = PH_LINE_COL;
                                    end
                                end
                            endcase
                        end
                        PH_LITERAL: begin
                            n_val      = w_b;
                            n_cnt      = 6'd1;
                            n_st       = ST_PIX;
                            n_lit_left = (e_lit_left != 6'd0) ? e_lit_left - 6'd1 : 6'd0;
                            if (n_lit_left == 6'd0) begin
                                n_phase = PH_CTRL;
                            end
                        end
                        PH_FILL_VAL: begin
                            n_val   = w_b;
                            n_cnt   = e_pend[5:0];
                            n_pend  = '0;
                            n_phase = PH_CTRL;
                            if (e_pend[5:0] != 6'd0) begin
                                n_st = ST_PIX;
                            end
                        end
                        PH_SKIP_BYTE: begin
                            n_opb   = srld_pkg::OPB_W'(w_b);
                            n_st    = ST_ADD;
                            n_phase = PH_CTRL;
                        end
                        PH_LINE_COUNT: begin
                            if (w_b == 8'd0) begin
                                n_st    = ST_END;
                                n_phase = PH_DONE;
                            end else begin
                                n_pend  = w_b;
                                n_phase = PH_LINE_COL;
                            end
                        end
                        PH_LINE_COL: begin
                            n_val   = w_b;
                            n_k     = 3'd0;
                            n_st    = ST_MUL;
                            n_phase = PH_CTRL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PIX: begin
                if (w_can_emit) begin
                    if (r_wptr[srld_pkg::ADDR_BITS]) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_ovld  = 1'b1;
                        n_oaddr = w_wptr_x[srld_pkg::PIX_ADDR_W-1:0];
                        n_oval  = r_val;
                        n_oend  = 1'b0;
                        n_oovf  = r_ovf;
                        n_olast = (r_cnt == 6'd1) || w_alu_sum[srld_pkg::ADDR_BITS];
                    end
                    n_wptr = w_alu_sum;
                    n_cnt  = r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        n_st = ST_IN;
                    end
                end
            end
            ST_ADD: begin
                n_wptr = w_alu_sum;
                n_st   = ST_IN;
            end
            ST_MUL: begin
                n_base = w_alu_sum;
                n_k    = r_k + 3'd1;
                if (r_k == 3'd7) begin
                    n_st = ST_COL;
                end
            end
            ST_COL: begin
                n_wptr = w_alu_sum;
                n_pend = '0;
                n_st   = ST_IN;
            end
            ST_END: begin
                if (w_can_emit) begin
                    n_ovld  = 1'b1;
                    n_oaddr = '0;
                    n_oval  = '0;
                    n_oend  = 1'b1;
                    n_oovf  = r_ovf;
                    n_olast = 1'b1;
                    n_st    = ST_IN;
                end
            end
            default: n_st = ST_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IN;
            r_phase    <= PH_RESET;
            r_hdr_left <= HDR_RESET;
            r_lit_left <= '0;
            r_pend     <= '0;
            r_ovf      <= 1'b0;
            r_base     <= '0;
            r_wptr     <= '0;
            r_pitch    <= 16'd256;
            r_ovld     <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_phase    <= n_phase;
            r_hdr_left <= n_hdr_left;
            r_lit_left <= n_lit_left;
            r_pend     <= n_pend;
            r_ovf      <= n_ovf;
            r_base     <= n_base;
            r_wptr     <= n_wptr;
            r_ovld     <= n_ovld;
            if (i_cfg_we) begin
                r_pitch <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_val   <= n_val;
        r_opb   <= n_opb;
        r_k     <= n_k;
        r_oaddr <= n_oaddr;
        r_oval  <= n_oval;
        r_oend  <= n_oend;
        r_oovf  <= n_oovf;
        r_olast <= n_olast;
    end

endmodule

// ===== rtl/srld_alu.sv =====
// Shared saturating pointer adder.
module srld_alu (
    input  srld_pkg::t_ptr i_a,
    input  srld_pkg::t_opb i_b,
    output srld_pkg::t_ptr o_sum
);

    logic [srld_pkg::SUM_W-1:0] w_sum;

    assign w_sum = srld_pkg::SUM_W'(i_a) + srld_pkg::SUM_W'(i_b);
    assign o_sum = (w_sum > srld_pkg::SUM_W'(srld_pkg::PTR_MAX)) ? srld_pkg::PTR_MAX
                                                                  : w_sum[srld_pkg::PTR_W-1:0];

endmodule
